// File: rtl/sphp_pkg.sv
// Shared types, constants and the arctangent table for the sphere patch unit.
// No dependencies; every other file in rtl/ imports this package.
package sphp_pkg;

  // Sizing of the mapping table and the angle datapath
  localparam int MAX_THETA_BINS = 64;
  localparam int MAX_PHI_BINS   = 32;
  localparam int MAX_PATCHES    = 512;
  localparam int CORDIC_STEPS   = 16;
  localparam int TABLE_DEPTH    = MAX_THETA_BINS * MAX_PHI_BINS;
  localparam int TBL_AW         = $clog2(TABLE_DEPTH);

  // Field and register widths
  localparam int NT_W  = 7;
  localparam int NP_W  = 6;
  localparam int TB_W  = 6;
  localparam int PB_W  = 5;
  localparam int IDX_W = 11;
  localparam int PAT_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // CORDIC datapath: vector lanes and angle accumulator (2^-32 turn units)
  localparam int CW = 36;
  localparam int AW = 36;
  localparam logic signed [AW-1:0] HALF_TURN    = 36'sh0_8000_0000;
  localparam logic signed [AW-1:0] QUARTER_TURN = 36'sh0_4000_0000;
  localparam logic signed [AW-1:0] FULL_TURN    = 36'sh1_0000_0000;

  // Queues
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int OQ_DEPTH = 64;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CAP   = OQ_DEPTH + 1;
  localparam int OCC_W    = $clog2(OQ_CAP + 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MAP   = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THETA_BINS = 1'b0,
    CFG_PHI_BINS   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                    opcode;
    logic signed [15:0]      vec_x;
    logic signed [15:0]      vec_y;
    logic signed [15:0]      vec_z;
    logic [IDX_W-1:0]        entry_index;
    logic [PAT_W-1:0]        entry_patch;
  } in_item_t;

  typedef struct packed {
    logic [PAT_W-1:0] patch_index;
    logic [TB_W-1:0]  theta_bin;
    logic [PB_W-1:0]  phi_bin;
  } out_item_t;

  // Request handed from the front queue to the back pipeline
  typedef struct packed {
    logic     vld;
    logic     is_map;
    in_item_t item;
  } issue_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [AW-1:0] ang;
  } cordic_t;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

endpackage

// File: rtl/sphp_front.sv
// Front queue: takes requests, classifies them and issues them to the back pipeline.
// Depends on sphp_pkg.
module sphp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  sphp_pkg::in_item_t in_data,
  input  logic              issue_ok,
  output sphp_pkg::issue_t  iss
);
  import sphp_pkg::*;

  in_item_t         fq [FQ_DEPTH];
  logic [FQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FQ_AW:0]   cnt_r, cnt_nxt;
  logic             acc;
  logic             head_map;

  // Classify the head request; map requests wait for a result slot
  always_comb begin
    head_map   = (fq[rp_r].opcode == OP_MAP);
    full       = (cnt_r == (FQ_AW+1)'(FQ_DEPTH));
    acc        = push && !full;
    iss.item   = fq[rp_r];
    iss.is_map = head_map;
    iss.vld    = (cnt_r != '0) && (!head_map || issue_ok);
    wp_nxt     = acc ? FQ_AW'(wp_r + 1'b1) : wp_r;
    rp_nxt     = iss.vld ? FQ_AW'(rp_r + 1'b1) : rp_r;
    cnt_nxt    = cnt_r + (FQ_AW+1)'(acc) - (FQ_AW+1)'(iss.vld);
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (acc) begin
      fq[wp_r] <= in_data;
    end
  end

endmodule

// File: rtl/sphp_back.sv
// Back pipeline: integer square root, azimuth and polar CORDIC, binning and the patch table.
// Depends on sphp_pkg.
module sphp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sphp_pkg::issue_t             iss,
  input  logic [sphp_pkg::NT_W-1:0]    nt,
  input  logic [sphp_pkg::NP_W-1:0]    np,
  output logic                         res_vld,
  output sphp_pkg::out_item_t          res
);
  import sphp_pkg::*;

  localparam int SQ_STEPS = 32;
  localparam int ST_TFIN  = SQ_STEPS + 1;
  localparam int ST_PFIN  = ST_TFIN + CORDIC_STEPS + 1;
  localparam int ST_QNT   = ST_PFIN + 1;
  localparam int LAST     = ST_QNT + 1;

  typedef struct packed {
    logic                vld;
    logic                is_map;
    logic                xy_zero;
    logic                all_zero;
    logic signed [15:0]  z;
    logic [IDX_W-1:0]    idx;
    logic [PAT_W-1:0]    patch;
    logic [63:0]         sv;
    logic [63:0]         sr;
    cordic_t             th;
    cordic_t             ph;
    logic [16:0]         th16;
    logic [16:0]         ph16;
    logic [TB_W-1:0]     tbin;
    logic [PB_W-1:0]     pbin;
    logic [TBL_AW-1:0]   addr;
  } stage_t;

  stage_t           st_r   [LAST+1];
  stage_t           st_nxt [LAST+1];
  logic [PAT_W-1:0] mem [TABLE_DEPTH];
  logic             res_vld_r;
  out_item_t        res_r;

  // Load a request into the first stage
  function automatic stage_t load_stage(issue_t q);
    stage_t            s;
    logic signed [CW-1:0] xs, ys, zs;
    logic signed [31:0] xw, yw;
    logic [31:0]       rr;
    s          = '0;
    xs         = $signed({{(CW-16){q.item.vec_x[15]}}, q.item.vec_x}) <<< 16;
    ys         = $signed({{(CW-16){q.item.vec_y[15]}}, q.item.vec_y}) <<< 16;
    zs         = $signed({{(CW-16){q.item.vec_z[15]}}, q.item.vec_z}) <<< 16;
    xw         = $signed({{16{q.item.vec_x[15]}}, q.item.vec_x});
    yw         = $signed({{16{q.item.vec_y[15]}}, q.item.vec_y});
    rr         = 32'(xw * xw) + 32'(yw * yw);
    s.vld      = q.vld;
    s.is_map   = q.is_map;
    s.xy_zero  = (q.item.vec_x == 16'sd0) && (q.item.vec_y == 16'sd0);
    s.all_zero = s.xy_zero && (q.item.vec_z == 16'sd0);
    s.z        = q.item.vec_z;
    s.idx      = q.item.entry_index;
    s.patch    = q.item.entry_patch;
    s.sv       = {rr, 32'h0};
    s.sr       = '0;
    if (q.item.vec_x < 16'sd0) begin
      s.th.a   = -xs;
      s.th.b   = -ys;
      s.th.ang = (q.item.vec_y >= 16'sd0) ? (HALF_TURN + HALF_TURN) : (HALF_TURN - HALF_TURN);
    end else begin
      s.th.a   = xs;
      s.th.b   = ys;
      s.th.ang = HALF_TURN;
    end
    s.ph.a = zs;
    return s;
  endfunction

  // One digit of the integer square root
  function automatic stage_t sqrt_step(stage_t s, logic [4:0] i);
    stage_t      o;
    logic [63:0] bitv, trial;
    o     = s;
    bitv  = 64'h4000_0000_0000_0000 >> {i, 1'b0};
    trial = s.sr + bitv;
    if (s.sv >= trial) begin
      o.sv = s.sv - trial;
      o.sr = (s.sr >> 1) + bitv;
    end else begin
      o.sr = s.sr >> 1;
    end
    return o;
  endfunction

  // One vectoring rotation
  function automatic cordic_t rot(cordic_t c, logic [4:0] i);
    cordic_t              o;
    logic signed [CW-1:0] da, db;
    logic signed [AW-1:0] at;
    da = c.b >>> i;
    db = c.a >>> i;
    at = $signed({{(AW-32){1'b0}}, ATAN_TAB[i]});
    if (c.b >= 0) begin
      o.a   = c.a + da;
      o.b   = c.b - db;
      o.ang = c.ang + at;
    end else begin
      o.a   = c.a - da;
      o.b   = c.b + db;
      o.ang = c.ang - at;
    end
    return o;
  endfunction

  // Finish the azimuth and set up the polar rotation
  function automatic stage_t theta_fin(stage_t s);
    stage_t               o;
    logic signed [AW-1:0] t, r, zs;
    o  = s;
    t  = s.th.ang;
    if (t < 0) t = '0;
    if (t > FULL_TURN) t = FULL_TURN;
    o.th16 = s.xy_zero ? 17'd0 : 17'((t + AW'(32768)) >>> 16);
    r  = $signed({{(CW-32){1'b0}}, s.sr[31:0]});
    zs = $signed({{(CW-16){s.z[15]}}, s.z}) <<< 16;
    if (s.z < 16'sd0) begin
      o.ph.a   = r;
      o.ph.b   = -zs;
      o.ph.ang = QUARTER_TURN;
    end else begin
      o.ph.a   = zs;
      o.ph.b   = r;
      o.ph.ang = '0;
    end
    return o;
  endfunction

  // Finish the polar angle
  function automatic stage_t phi_fin(stage_t s);
    stage_t               o;
    logic signed [AW-1:0] p;
    o = s;
    p = s.ph.ang;
    if (p < 0) p = '0;
    if (p > HALF_TURN) p = HALF_TURN;
    o.ph16 = s.all_zero ? 17'd0 : 17'((p + AW'(16384)) >>> 15);
    return o;
  endfunction

  // Quantize both angles to clamped bins
  function automatic stage_t quant(stage_t s, logic [NT_W-1:0] n_t, logic [NP_W-1:0] n_p);
    stage_t          o;
    logic [23:0]     pt;
    logic [22:0]     pp;
    logic [NT_W:0]   bt;
    logic [NP_W:0]   bp;
    o  = s;
    pt = 24'(s.th16) * 24'(n_t);
    pp = 23'(s.ph16) * 23'(n_p);
    bt = pt[23:16];
    bp = pp[22:16];
    if (bt > (NT_W+1)'(n_t - 1'b1)) bt = (NT_W+1)'(n_t - 1'b1);
    if (bp > (NP_W+1)'(n_p - 1'b1)) bp = (NP_W+1)'(n_p - 1'b1);
    o.tbin = bt[TB_W-1:0];
    o.pbin = bp[PB_W-1:0];
    return o;
  endfunction

  // Compute each stage from the one before it; drop valid bits in reset
  always_comb begin
    st_nxt[0] = load_stage(iss);
    if (!rst_n) begin
      st_nxt[0].vld = 1'b0;
    end
    for (int k = 1; k <= LAST; k++) begin
      st_nxt[k] = st_r[k-1];
      if (k <= SQ_STEPS) begin
        st_nxt[k] = sqrt_step(st_nxt[k], 5'(k-1));
        if (k - 1 < CORDIC_STEPS) begin
          st_nxt[k].th = rot(st_nxt[k].th, 5'(k-1));
        end
      end
      if (k == ST_TFIN) begin
        st_nxt[k] = theta_fin(st_nxt[k]);
      end
      if (k > ST_TFIN && k < ST_PFIN) begin
        st_nxt[k].ph = rot(st_nxt[k].ph, 5'(k-ST_TFIN-1));
      end
      if (k == ST_PFIN) begin
        st_nxt[k] = phi_fin(st_nxt[k]);
      end
      if (k == ST_QNT) begin
        st_nxt[k] = quant(st_nxt[k], nt, np);
      end
      if (k == LAST) begin
        st_nxt[k].addr = TBL_AW'((TB_W+NP_W+1)'(st_r[k-1].tbin) * (TB_W+NP_W+1)'(np)
                                 + (TB_W+NP_W+1)'(st_r[k-1].pbin));
      end
      if (!rst_n) begin
        st_nxt[k].vld = 1'b0;
      end
    end
  end

  // Advance the pipeline
  always_ff @(posedge clk) begin
    for (int k = 0; k <= LAST; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

  // Write or read the patch table
  always_ff @(posedge clk) begin
    if (st_r[LAST].vld && !st_r[LAST].is_map && (st_r[LAST].idx < TABLE_DEPTH)) begin
      if (st_r[LAST].patch > PAT_W'(MAX_PATCHES - 1)) begin
        mem[st_r[LAST].idx[TBL_AW-1:0]] <= PAT_W'(MAX_PATCHES - 1);
      end else begin
        mem[st_r[LAST].idx[TBL_AW-1:0]] <= st_r[LAST].patch;
      end
    end
    res_r.patch_index <= mem[st_r[LAST].addr];
    res_r.theta_bin   <= st_r[LAST].tbin;
    res_r.phi_bin     <= st_r[LAST].pbin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= st_r[LAST].vld && st_r[LAST].is_map;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

// File: rtl/sphp_outq.sv
// Result queue: memory-backed FIFO with a registered head, first word on the ports.
// Depends on sphp_pkg.
module sphp_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr,
  input  sphp_pkg::out_item_t         wdata,
  input  logic                        pop,
  output logic                        empty,
  output sphp_pkg::out_item_t         rdata,
  output logic [sphp_pkg::OCC_W-1:0]  occ
);
  import sphp_pkg::*;

  out_item_t        mem [OQ_DEPTH];
  out_item_t        dout_r;
  logic             dv_r, dv_nxt;
  logic [OQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;
  logic             load, mem_rd, mem_wr, byp;

  // Refill the head from memory, or straight from the write when memory is empty
  always_comb begin
    load    = !dv_r || pop;
    mem_rd  = load && (cnt_r != '0);
    byp     = load && (cnt_r == '0) && wr;
    mem_wr  = wr && !byp;
    dv_nxt  = load ? (mem_rd || byp) : dv_r;
    wp_nxt  = mem_wr ? OQ_AW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = mem_rd ? OQ_AW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (OQ_AW+1)'(mem_wr) - (OQ_AW+1)'(mem_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r  <= 1'b0;
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      dv_r  <= dv_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wp_r] <= wdata;
    end
    if (mem_rd) begin
      dout_r <= mem[rp_r];
    end else if (byp) begin
      dout_r <= wdata;
    end
  end

  assign empty = !dv_r;
  assign rdata = dout_r;
  assign occ   = OCC_W'(cnt_r) + OCC_W'(dv_r);

endmodule

// File: rtl/vector_direction_to_sphere_patch_unit.sv
// Top level of the sphere patch unit: configuration, result credits and the three parts.
// Depends on sphp_pkg, sphp_front, sphp_back and sphp_outq.
//
//   channel   ports                                   handshake
//   input     push, full, in_data                     push && !full
//   result    empty, pop, out_data                    pop && !empty
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid && cfg_ready
//
// One request enters per cycle while the front queue is not full. On its way to the result
// ports a map request passes 32 square-root digit stages, 16 polar CORDIC stages, binning,
// the table address and the table read. Writes take the same path and give no result.
// The result queue holds 65 results; map requests wait in the front queue while that
// many are queued or in flight. Reset is synchronous and clears both queues.
module vector_direction_to_sphere_patch_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  sphp_pkg::in_item_t                in_data,
  output logic                              empty,
  input  logic                              pop,
  output sphp_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sphp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sphp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sphp_pkg::*;

  logic [NT_W-1:0]  theta_bins_r;
  logic [NP_W-1:0]  phi_bins_r;
  logic [NT_W-1:0]  nt;
  logic [NP_W-1:0]  np;
  logic [OCC_W-1:0] inflight_r, inflight_nxt;
  logic [OCC_W-1:0] occ;
  logic             issue_ok;
  issue_t           iss;
  logic             res_vld;
  out_item_t        res;

  assign cfg_ready = 1'b1;

  // Hold the bin count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_bins_r <= NT_W'(MAX_THETA_BINS);
      phi_bins_r   <= NP_W'(MAX_PHI_BINS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_THETA_BINS: theta_bins_r <= cfg_data[NT_W-1:0];
        CFG_PHI_BINS:   phi_bins_r   <= cfg_data[NP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the bin counts to the table shape
  always_comb begin
    if (theta_bins_r == '0) begin
      nt = NT_W'(1);
    end else if (theta_bins_r > NT_W'(MAX_THETA_BINS)) begin
      nt = NT_W'(MAX_THETA_BINS);
    end else begin
      nt = theta_bins_r;
    end
    if (phi_bins_r == '0) begin
      np = NP_W'(1);
    end else if (phi_bins_r > NP_W'(MAX_PHI_BINS)) begin
      np = NP_W'(MAX_PHI_BINS);
    end else begin
      np = phi_bins_r;
    end
  end

  // Track map requests in flight against free result slots
  always_comb begin
    issue_ok     = ((OCC_W+1)'(occ) + (OCC_W+1)'(inflight_r)) < (OCC_W+1)'(OQ_CAP);
    inflight_nxt = inflight_r + OCC_W'(iss.vld && iss.is_map) - OCC_W'(res_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  sphp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .issue_ok (issue_ok),
    .iss      (iss)
  );

  sphp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .iss     (iss),
    .nt      (nt),
    .np      (np),
    .res_vld (res_vld),
    .res     (res)
  );

  sphp_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_vld),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (out_data),
    .occ   (occ)
  );

endmodule

// File: rtl/sphp_checker.sv
// Port-level checks for the sphere patch unit, bound to the top level.
// Depends on sphp_pkg and vector_direction_to_sphere_patch_unit.
module sphp_port_checks (
  input logic                clk,
  input logic                rst_n,
  input logic                push,
  input logic                full,
  input logic                pop,
  input logic                empty,
  input sphp_pkg::out_item_t out_data
);
  import sphp_pkg::*;

  // The result queue comes out of reset empty
  a_empty_after_reset: assert property (@(posedge clk) rst_n && !$past(rst_n) |-> empty)
    else $error("result queue not empty after reset");

  // Input queue fills only by an accepted request
  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push && !full))
    else $error("input queue became full without a request");

  // A waiting result stays until taken
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty)
    else $error("waiting result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> $stable(out_data))
    else $error("waiting result changed");

endmodule

bind vector_direction_to_sphere_patch_unit sphp_port_checks u_sphp_port_checks (.*);

// File: dv/sphp_checker.sv
// Result checker for the sphere patch unit: watches the input, result and config channels.
// Depends on sphp_pkg; predicts each map request and compares it with the popped result.
module sphp_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic                            full,
  input  sphp_pkg::in_item_t              in_data,
  input  logic                            empty,
  input  logic                            pop,
  input  sphp_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sphp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sphp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import sphp_pkg::*;

  localparam longint HALF_T    = 64'sd2147483648;
  localparam longint QUARTER_T = 64'sd1073741824;
  localparam longint FULL_T    = 64'sd4294967296;

  logic [PAT_W-1:0] patch_table [TABLE_DEPTH];
  logic [NT_W-1:0]  theta_count;
  logic [NP_W-1:0]  phi_count;
  out_item_t        patch_expect_q [$];

  // Exact integer square root
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bit_pos;
    res = 0;
    bit_pos = 64'd1 << 62;
    while (bit_pos > v) bit_pos >>= 2;
    while (bit_pos != 0) begin
      if (v >= res + bit_pos) begin
        v -= res + bit_pos;
        res = (res >> 1) + bit_pos;
      end else begin
        res >>= 1;
      end
      bit_pos >>= 2;
    end
    return res;
  endfunction

  // Vectoring rotation; angle in 2^-32 turn units, a must be non-negative
  function automatic longint turn_angle(longint a, longint b);
    longint ang, da, db;
    ang = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da; b -= db; ang += longint'(ATAN_TAB[i]);
      end else begin
        a -= da; b += db; ang -= longint'(ATAN_TAB[i]);
      end
    end
    return ang;
  endfunction

  function automatic int bin_of(longint frac16, int n);
    longint b;
    b = (frac16 * n) >>> 16;
    return (b > n - 1) ? n - 1 : int'(b);
  endfunction

  // Direction to bins and table lookup
  function automatic out_item_t sphere_patch_of(in_item_t it);
    longint x, y, z, th, ph, a, b, base, r, t;
    int nt, np, tb, pb, addr;
    out_item_t res;
    x = longint'($signed(it.vec_x));
    y = longint'($signed(it.vec_y));
    z = longint'($signed(it.vec_z));
    if (x == 0 && y == 0) begin
      th = 0;
    end else begin
      a = x * 65536; b = y * 65536; base = 0;
      if (x < 0) begin
        a = -a; b = -b;
        base = (y >= 0) ? HALF_T : -HALF_T;
      end
      th = base + turn_angle(a, b) + HALF_T;
      if (th < 0) th = 0;
      if (th > FULL_T) th = FULL_T;
      th = (th + 32768) >>> 16;
    end
    if (x == 0 && y == 0 && z == 0) begin
      ph = 0;
    end else begin
      r = longint'(root64(longint'(x * x + y * y) << 32));
      a = z * 65536; b = r; base = 0;
      if (a < 0) begin
        t = a; a = b; b = -t;
        base = QUARTER_T;
      end
      ph = base + turn_angle(a, b);
      if (ph < 0) ph = 0;
      if (ph > HALF_T) ph = HALF_T;
      ph = (ph + 16384) >>> 15;
    end
    nt = (theta_count == 0) ? 1 : (theta_count > MAX_THETA_BINS ? MAX_THETA_BINS : theta_count);
    np = (phi_count == 0) ? 1 : (phi_count > MAX_PHI_BINS ? MAX_PHI_BINS : phi_count);
    tb = bin_of(th, nt);
    pb = bin_of(ph, np);
    addr = tb * np + pb;
    res.patch_index = (addr < TABLE_DEPTH) ? patch_table[addr] : '0;
    res.theta_bin   = tb[TB_W-1:0];
    res.phi_bin     = pb[PB_W-1:0];
    return res;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Watch all three channels at each rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      theta_count = 7'd64;
      phi_count   = 6'd32;
      patch_expect_q.delete();
    end else begin
      // compare popped result
      if (pop && !empty) begin
        if (patch_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %p", out_data);
        end else begin
          want = patch_expect_q.pop_front();
          if (out_data.patch_index !== want.patch_index ||
              out_data.theta_bin !== want.theta_bin ||
              out_data.phi_bin !== want.phi_bin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, actual %p", want, out_data);
          end
        end
      end
      // predict accepted request
      if (push && !full) begin
        if (in_data.opcode == OP_WRITE) begin
          if (in_data.entry_index < TABLE_DEPTH)
            patch_table[in_data.entry_index] =
              (in_data.entry_patch > MAX_PATCHES - 1) ? PAT_W'(MAX_PATCHES - 1)
                                                      : in_data.entry_patch;
        end else begin
          patch_expect_q.push_back(sphere_patch_of(in_data));
        end
      end
      // track bin counts
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THETA_BINS) theta_count = cfg_data[NT_W-1:0];
        else phi_count = cfg_data[NP_W-1:0];
      end
    end
    outstanding = patch_expect_q.size();
  end

endmodule

// File: dv/vector_direction_to_sphere_patch_unit_test.sv
// Testbench top for the sphere patch unit: clock, reset, stimulus, receiver stalls, verdict.
// Depends on sphp_pkg, the unit itself and sphp_checker.
module vector_direction_to_sphere_patch_unit_test;
  import sphp_pkg::*;

  localparam int FILL_DEPTH = 256;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  in_item_t              in_data = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;
  logic                  hold_off_go = 1'b0;
  int                    burst_left = 0;

  always #10 clk = ~clk;

  vector_direction_to_sphere_patch_unit DUT (.*);

  sphp_checker u_checker (.*);

  // Send one request; return once it was taken, after an idle gap when a burst ends
  task automatic send_request(in_item_t it);
    in_data <= it;
    push    <= 1'b1;
    while (full) @(negedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_map(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_item_t it;
    it = '0;
    it.opcode = OP_MAP;
    it.vec_x = x; it.vec_y = y; it.vec_z = z;
    it.entry_index = IDX_W'($urandom);
    it.entry_patch = PAT_W'($urandom);
    send_request(it);
  endtask

  task automatic send_write(int idx, int patch);
    in_item_t it;
    it = '0;
    it.opcode = OP_WRITE;
    it.vec_x = 16'($urandom); it.vec_y = 16'($urandom); it.vec_z = 16'($urandom);
    it.entry_index = IDX_W'(idx);
    it.entry_patch = PAT_W'(patch);
    send_request(it);
  endtask

  // Write one bin count once the unit has drained
  task automatic write_bins(cfg_reg_t which, int value);
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_index <= which;
    cfg_data  <= CFG_DATA_W'(value);
    cfg_valid <= 1'b1;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_component();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'($signed($urandom_range(0, 8)) - 4);
      2:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: stall pattern that changes mode at random, plus one long hold-off
  initial begin
    int mode, hold_cycles;
    mode = 0;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_off_go && hold_cycles == 0) hold_cycles = 600;
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold_cycles > 1) begin
        pop <= 1'b0;
        hold_cycles--;
      end else begin
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= ($urandom_range(0, 3) != 0);
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill the low table entries; every bin setting below keeps lookups inside them
    for (int i = 0; i < FILL_DEPTH; i++) send_write(i, $urandom_range(0, MAX_PATCHES - 1));

    // directed: extremes, axes and degenerate directions
    write_bins(CFG_THETA_BINS, 16);
    write_bins(CFG_PHI_BINS, 16);
    send_write(TABLE_DEPTH - 1, MAX_PATCHES - 1);
    send_write(0, 0);
    send_map(16'h0000, 16'h0000, 16'h0000);
    send_map(16'h0000, 16'h0000, 16'h0005);
    send_map(16'h0000, 16'h0000, 16'hFFFB);
    send_map(16'h0000, 16'h0000, 16'h8000);
    send_map(16'h8000, 16'h0000, 16'h0000);
    send_map(16'hFFFF, 16'h0000, 16'h0001);
    send_map(16'h7FFF, 16'h0000, 16'h0000);
    send_map(16'h0000, 16'h7FFF, 16'h0000);
    send_map(16'h0000, 16'h8000, 16'h0000);
    send_map(16'h8000, 16'h8000, 16'h8000);
    send_map(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_map(16'h8000, 16'h7FFF, 16'h8000);
    send_map(16'h0001, 16'hFFFF, 16'h0000);
    send_map(16'hFFFB, 16'h0003, 16'hFFF9);

    // bin count settings: zero, above range, one, maximum, then random
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_bins(CFG_THETA_BINS, 0);   write_bins(CFG_PHI_BINS, 0);  end
        1: begin write_bins(CFG_THETA_BINS, 127); write_bins(CFG_PHI_BINS, 4);  end
        2: begin write_bins(CFG_THETA_BINS, 1);   write_bins(CFG_PHI_BINS, 63); end
        3: begin write_bins(CFG_THETA_BINS, 64);  write_bins(CFG_PHI_BINS, 1);  end
        default: begin
          write_bins(CFG_THETA_BINS, $urandom_range(1, 16));
          write_bins(CFG_PHI_BINS, $urandom_range(1, 16));
        end
      endcase
      send_map(16'h8000, 16'h0000, 16'h8000);
      send_map(16'h0000, 16'h0000, 16'h7FFF);
      for (int n = 0; n < 100; n++) begin
        if (ph == 4 && n == 0) hold_off_go <= 1'b1;
        if ($urandom_range(0, 4) == 0)
          send_write($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, MAX_PATCHES - 1));
        else
          send_map(rand_component(), rand_component(), rand_component());
      end
    end

    // drain
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
rtl/sphp_pkg.sv
rtl/sphp_front.sv
rtl/sphp_back.sv
rtl/sphp_outq.sv
rtl/vector_direction_to_sphere_patch_unit.sv
rtl/sphp_checker.sv
dv/sphp_checker.sv
dv/vector_direction_to_sphere_patch_unit_test.sv
